// File: rtl/core/pose_to_target_range_bearing_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pose to target range and bearing block
// Concurrent checks in simulation; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef POSE_TO_TARGET_RANGE_BEARING_DEFINES_SVH
`define POSE_TO_TARGET_RANGE_BEARING_DEFINES_SVH
`ifndef SYNTHESIS
// check outside reset
`define PTTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define PTTRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTTRB_ASSERT(lbl, prop, msg)
`define PTTRB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/pttrb_pkg.sv
// ----------------------------------------------------------------------------
// pttrb_pkg
// Widths, constants, stage payload types and the arctangent table for the
// range and bearing pipeline.
// ----------------------------------------------------------------------------
package pttrb_pkg;

  // Build-time configuration
  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  // Field widths
  localparam int XF_W        = 16;
  localparam int HEAD_W      = 32;
  localparam int DIST_W      = 17;
  localparam int TURN_W      = 10;
  localparam int IN_TDATA_W  = 4 * XF_W + HEAD_W;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DIST_W - TURN_W;

  // Internal widths
  localparam int VEC_FRAC = 12;
  localparam int DW       = COORD_BITS + 1;          // offset
  localparam int SW       = COORD_BITS;              // exact axis distance
  localparam int VW       = DW + VEC_FRAC + 2;       // CORDIC vector
  localparam int UW       = VW - 1;                  // non-negative final x
  localparam int ZW       = 27;                      // angle, 1/65536 degree
  localparam int HW       = 17;                      // wrapped heading, 1/256 degree
  localparam int DFW      = ZW + 1;                  // turn difference

  localparam int BEAR_FRAC = 16;
  localparam int HEAD_FRAC = 8;

  // Heading wrap: a full turn is 45 << 11 steps, and 2^12 is 1 modulo 45
  localparam int FULL_TURN_H = 92160;
  localparam int HALF_TURN_H = 46080;
  localparam int HEAD_LOW_W  = 11;
  localparam int HEAD_MOD    = 45;
  localparam int HM_W        = HEAD_W - HEAD_LOW_W;
  localparam int FOLD_W      = 12;
  localparam int FOLD_SUM_W  = FOLD_W + 1;
  localparam int RECIP       = 2913;                 // ceil(2^17 / 45)
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 12;
  localparam int PROD_W      = FOLD_SUM_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int REM_W       = 6;

  // Bearing constants
  localparam int HALF_TURN_B = 11796480;
  localparam logic signed [ZW-1:0] BEAR_HALF    = ZW'(HALF_TURN_B);
  localparam logic signed [ZW-1:0] BEAR_QUARTER = ZW'(HALF_TURN_B / 2);
  localparam logic signed [ZW-1:0] BEAR_MIN     = ZW'(1 - HALF_TURN_B);

  // Range scaling by the inverse CORDIC gain, 2^30 scale
  localparam longint INV_GAIN   = 652032874;
  localparam int     KW         = 30;
  localparam int     SPLIT      = 16;
  localparam int     GAIN_SHIFT = 30 + VEC_FRAC - SPLIT;
  localparam int     PHW        = UW - SPLIT + KW;
  localparam int     PLW        = SPLIT + KW;
  localparam int     SUMW       = PHW + 1;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 exact;   // zero or on-axis offset: take sdist / sbear
    logic [SW-1:0]        sdist;
    logic signed [ZW-1:0] sbear;
    logic signed [HW-1:0] head;
  } vec_t;

  typedef struct packed {
    logic valid;
    vec_t vec;
  } pipe_t;

  // atan(2^-i) in degrees, 1/65536 degree units
  function automatic logic signed [ZW-1:0] atan_deg16(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = ZW'(2949120);
      1:       a = ZW'(1740967);
      2:       a = ZW'(919879);
      3:       a = ZW'(466945);
      4:       a = ZW'(234379);
      5:       a = ZW'(117304);
      6:       a = ZW'(58666);
      7:       a = ZW'(29335);
      8:       a = ZW'(14668);
      9:       a = ZW'(7334);
      10:      a = ZW'(3667);
      11:      a = ZW'(1833);
      12:      a = ZW'(917);
      13:      a = ZW'(458);
      14:      a = ZW'(229);
      15:      a = ZW'(115);
      16:      a = ZW'(57);
      17:      a = ZW'(29);
      18:      a = ZW'(14);
      19:      a = ZW'(7);
      20:      a = ZW'(4);
      21:      a = ZW'(2);
      22:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Take the low COORD_BITS of a coordinate field as two's complement
  function automatic logic signed [COORD_BITS-1:0] coord_ext(input logic [XF_W-1:0] f);
    logic [63:0] t;
    t = 64'(f);
    return t[COORD_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/pttrb_prep.sv
// ----------------------------------------------------------------------------
// pttrb_prep
// Two pipeline stages: offset and heading fold, then heading wrap, axis
// detection and the half-plane pre-rotation of the CORDIC vector.
// ----------------------------------------------------------------------------
module pttrb_prep import pttrb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [XF_W-1:0]   cur_x,
  input  logic [XF_W-1:0]   cur_y,
  input  logic [HEAD_W-1:0] heading,
  input  logic [XF_W-1:0]   target_x,
  input  logic [XF_W-1:0]   target_y,
  output pipe_t             dn,
  input  logic              dn_ready
);

  localparam logic signed [HW:0] HALF_H = (HW + 1)'(HALF_TURN_H);
  localparam logic signed [HW:0] FULL_H = (HW + 1)'(FULL_TURN_H);

  // Stage A registers
  logic                   a_vld_r;
  logic signed [DW-1:0]   a_dx_r, a_dy_r;
  logic                   a_hneg_r;
  logic [HEAD_LOW_W-1:0]  a_low_r;
  logic [FOLD_SUM_W-1:0]  a_fold_r;

  // Stage B registers
  logic b_vld_r;
  vec_t b_vec_r;

  logic a_rdy, b_rdy;

  // Stage A next values
  logic signed [COORD_BITS-1:0] cx, cy, tx, ty;
  logic [HEAD_W-1:0]            mag;
  logic [HM_W-1:0]              hm;
  logic [FOLD_SUM_W-1:0]        fold1, fold_nxt;
  logic signed [DW-1:0]         dx_nxt, dy_nxt;

  // Stage B next values
  logic [PROD_W-1:0]      prod;
  logic [Q_W-1:0]         quo;
  logic [FOLD_SUM_W-1:0]  rem_full;
  logic [REM_W-1:0]       rem;
  logic [HW-1:0]          magmod;
  logic signed [HW:0]     hs, hw;
  logic                   dxz, dyz, dxneg, dypos;
  logic signed [VW-1:0]   xs, ys;
  vec_t                   b_vec_nxt;

  // Handshake: a stage loads when empty or when its content moves on
  assign b_rdy    = !b_vld_r || dn_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // Offsets and heading magnitude folded modulo 45 above the low bits
  always_comb begin
    cx       = coord_ext(cur_x);
    cy       = coord_ext(cur_y);
    tx       = coord_ext(target_x);
    ty       = coord_ext(target_y);
    dx_nxt   = DW'(tx) - DW'(cx);
    dy_nxt   = DW'(ty) - DW'(cy);
    mag      = heading[HEAD_W-1] ? (~heading + 1'b1) : heading;
    hm       = mag[HEAD_W-1:HEAD_LOW_W];
    fold1    = FOLD_SUM_W'(hm[FOLD_W-1:0]) + FOLD_SUM_W'(hm[HM_W-1:FOLD_W]);
    fold_nxt = FOLD_SUM_W'(fold1[FOLD_W-1:0]) + FOLD_SUM_W'(fold1[FOLD_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_dx_r   <= dx_nxt;
      a_dy_r   <= dy_nxt;
      a_hneg_r <= heading[HEAD_W-1];
      a_low_r  <= mag[HEAD_LOW_W-1:0];
      a_fold_r <= fold_nxt;
    end
  end

  // Finish the modulo, restore the sign, wrap; classify and pre-rotate
  always_comb begin
    prod     = PROD_W'(a_fold_r) * PROD_W'(RECIP);
    quo      = prod[PROD_W-1:RECIP_SHIFT];
    rem_full = a_fold_r - FOLD_SUM_W'(FOLD_SUM_W'(quo) * FOLD_SUM_W'(HEAD_MOD));
    rem      = rem_full[REM_W-1:0];
    magmod   = {rem, a_low_r};
    hs       = a_hneg_r ? -$signed({1'b0, magmod}) : $signed({1'b0, magmod});
    if (hs > HALF_H) begin
      hw = hs - FULL_H;
    end else if (hs <= -HALF_H) begin
      hw = hs + FULL_H;
    end else begin
      hw = hs;
    end

    dxz   = (a_dx_r == '0);
    dyz   = (a_dy_r == '0);
    dxneg = a_dx_r[DW-1];
    dypos = !a_dy_r[DW-1] && !dyz;
    xs    = VW'(a_dx_r) <<< VEC_FRAC;
    ys    = VW'(a_dy_r) <<< VEC_FRAC;

    b_vec_nxt.x     = dxneg ? -xs : xs;
    b_vec_nxt.y     = dxneg ? -ys : ys;
    b_vec_nxt.z     = dxneg ? (dypos ? BEAR_HALF : -BEAR_HALF) : '0;
    b_vec_nxt.exact = dxz || dyz;
    if (dyz) begin
      b_vec_nxt.sdist = SW'(dxneg ? -a_dx_r : a_dx_r);
    end else begin
      b_vec_nxt.sdist = SW'(a_dy_r[DW-1] ? -a_dy_r : a_dy_r);
    end
    if (dxz && dyz) begin
      b_vec_nxt.sbear = '0;
    end else if (dyz) begin
      b_vec_nxt.sbear = dxneg ? BEAR_HALF : '0;
    end else begin
      b_vec_nxt.sbear = dypos ? BEAR_QUARTER : -BEAR_QUARTER;
    end
    b_vec_nxt.head = hw[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_vec_r <= b_vec_nxt;
    end
  end

  assign dn = '{valid: b_vld_r, vec: b_vec_r};

endmodule

// File: rtl/core/pttrb_cordic.sv
// ----------------------------------------------------------------------------
// pttrb_cordic
// Unrolled CORDIC vectoring, one rotation per register stage. Each stage
// drives y towards zero and accumulates the rotation angle in z.
// ----------------------------------------------------------------------------
module pttrb_cordic import pttrb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t up,
  output logic  up_ready,
  output pipe_t dn,
  input  logic  dn_ready
);

  logic [CORDIC_STEPS-1:0] vld_r;
  vec_t                    dat_r [CORDIC_STEPS];
  logic [CORDIC_STEPS:0]   rdy;

  assign rdy[CORDIC_STEPS] = dn_ready;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic src_vld;
    vec_t src;
    vec_t nxt;

    if (i == 0) begin : g_first
      assign src_vld = up.valid;
      assign src     = up.vec;
    end else begin : g_next
      assign src_vld = vld_r[i-1];
      assign src     = dat_r[i-1];
    end

    // Stage loads when empty or when its content moves on
    assign rdy[i] = !vld_r[i] || rdy[i+1];

    // Rotate by atan(2^-i) towards the x axis
    always_comb begin
      nxt = src;
      if (!src.y[VW-1]) begin
        nxt.x = src.x + (src.y >>> i);
        nxt.y = src.y - (src.x >>> i);
        nxt.z = src.z + atan_deg16(i);
      end else begin
        nxt.x = src.x - (src.y >>> i);
        nxt.y = src.y + (src.x >>> i);
        nxt.z = src.z - atan_deg16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        dat_r[i] <= nxt;
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn       = '{valid: vld_r[CORDIC_STEPS-1], vec: dat_r[CORDIC_STEPS-1]};

endmodule

// File: rtl/core/pttrb_finish.sv
// ----------------------------------------------------------------------------
// pttrb_finish
// Gain correction of the CORDIC range, bearing clamp, turn angle and the
// output register.
// ----------------------------------------------------------------------------
module pttrb_finish import pttrb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_t                    up,
  output logic                     up_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DIST_W-1:0]        distance,
  output logic signed [TURN_W-1:0] turn_degrees
);

  localparam logic signed [DFW-1:0] TRUNC_BIAS = DFW'((1 << BEAR_FRAC) - 1);

  // Product stage
  logic                 m_vld_r;
  logic [PHW-1:0]       m_phi_r;
  logic [PLW-1:0]       m_plo_r;
  logic                 m_exact_r;
  logic [SW-1:0]        m_sdist_r;
  logic signed [ZW-1:0] m_bear_r;
  logic signed [HW-1:0] m_head_r;

  // Output stage
  logic                     o_vld_r;
  logic [DIST_W-1:0]        o_dist_r;
  logic signed [TURN_W-1:0] o_turn_r;

  logic m_rdy, o_rdy;

  logic [UW-1:0]        ux;
  logic [PHW-1:0]       phi_nxt;
  logic [PLW-1:0]       plo_nxt;
  logic signed [ZW-1:0] bear_nxt;

  logic [SUMW-1:0]       sum;
  logic [DIST_W-1:0]     dist_nxt;
  logic signed [DFW-1:0] diff, adj, turn_full;

  assign o_rdy    = !o_vld_r || out_ready;
  assign m_rdy    = !m_vld_r || o_rdy;
  assign up_ready = m_rdy;

  // Split the range into two partial products; clamp the bearing
  always_comb begin
    ux      = up.vec.x[VW-1] ? '0 : up.vec.x[UW-1:0];
    phi_nxt = PHW'(ux[UW-1:SPLIT]) * PHW'(INV_GAIN);
    plo_nxt = PLW'(ux[SPLIT-1:0]) * PLW'(INV_GAIN);
    if (up.vec.exact) begin
      bear_nxt = up.vec.sbear;
    end else if (up.vec.z > BEAR_HALF) begin
      bear_nxt = BEAR_HALF;
    end else if (up.vec.z < BEAR_MIN) begin
      bear_nxt = BEAR_MIN;
    end else begin
      bear_nxt = up.vec.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_rdy) begin
      m_vld_r <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy) begin
      m_phi_r   <= phi_nxt;
      m_plo_r   <= plo_nxt;
      m_exact_r <= up.vec.exact;
      m_sdist_r <= up.vec.sdist;
      m_bear_r  <= bear_nxt;
      m_head_r  <= up.vec.head;
    end
  end

  // Sum the partial products; bearing minus heading, truncated toward zero
  always_comb begin
    sum       = SUMW'(m_phi_r) + SUMW'(m_plo_r >> SPLIT);
    dist_nxt  = m_exact_r ? DIST_W'(m_sdist_r) : DIST_W'(sum >> GAIN_SHIFT);
    diff      = DFW'(m_bear_r) - (DFW'(m_head_r) <<< (BEAR_FRAC - HEAD_FRAC));
    adj       = diff[DFW-1] ? (diff + TRUNC_BIAS) : diff;
    turn_full = adj >>> BEAR_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_dist_r <= dist_nxt;
      o_turn_r <= turn_full[TURN_W-1:0];
    end
  end

  assign out_valid    = o_vld_r;
  assign distance     = o_dist_r;
  assign turn_degrees = o_turn_r;

endmodule

// File: rtl/core/pose_to_target_range_bearing.sv
// ----------------------------------------------------------------------------
// pose_to_target_range_bearing
// Range and turn angle from a robot pose to a target position.
// One request on the in_ channel carries current x/y, heading and target x/y;
// each request yields exactly one result on the out_ channel: the floor of
// the distance and the turn angle in whole degrees (bearing minus the heading
// wrapped into (-180, 180], truncated toward zero).
// Throughput: one request per cycle, sustained while the receiver accepts results.
// Stages from acceptance to out_tvalid: two preparation stages, one stage per
// CORDIC rotation (CORDIC_STEPS), then a product stage and the output register.
// Reset clears every stage valid bit; no request is in flight afterwards and
// in_tready is high. When the receiver stalls, the result waits in the output
// register and earlier stages keep filling their bubbles; in_tready falls only
// once every stage holds a request.
// ----------------------------------------------------------------------------
`include "pose_to_target_range_bearing_defines.svh"

module pose_to_target_range_bearing import pttrb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cur_x[15:0], cur_y[31:16], heading[63:32], target_x[79:64], target_y[95:80]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // distance[16:0], turn_degrees[26:17], zero[31:27]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic signed [TURN_W-1:0] TURN_LIM = TURN_W'(359);

  pipe_t                    prep_dn, cordic_dn;
  logic                     prep_rdy, cordic_rdy;
  logic [DIST_W-1:0]        dist_val;
  logic signed [TURN_W-1:0] turn;

  // Offset, heading wrap and pre-rotation
  pttrb_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cur_x    (in_tdata[XF_W-1:0]),
    .cur_y    (in_tdata[2*XF_W-1:XF_W]),
    .heading  (in_tdata[2*XF_W+HEAD_W-1:2*XF_W]),
    .target_x (in_tdata[3*XF_W+HEAD_W-1:2*XF_W+HEAD_W]),
    .target_y (in_tdata[4*XF_W+HEAD_W-1:3*XF_W+HEAD_W]),
    .dn       (prep_dn),
    .dn_ready (prep_rdy)
  );

  // Vectoring rotations
  pttrb_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up       (prep_dn),
    .up_ready (prep_rdy),
    .dn       (cordic_dn),
    .dn_ready (cordic_rdy)
  );

  // Gain correction, turn angle, output register
  pttrb_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .up           (cordic_dn),
    .up_ready     (cordic_rdy),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .distance     (dist_val),
    .turn_degrees (turn)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, turn, dist_val};

  // Checks
  `PTTRB_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `PTTRB_ASSERT(a_stall_only_full, !in_tready |-> out_tvalid && !out_tready, "input stalled without a blocked result")
  `PTTRB_ASSERT(a_turn_range, out_tvalid |-> (turn >= -TURN_LIM) && (turn <= TURN_LIM), "turn angle out of range")

endmodule

// File: test/tb_pose_to_target_range_bearing.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pose_to_target_range_bearing
// Self-checking bench for the range and bearing pipeline. A directed set covers
// zero and on-axis offsets, offsets pointing backwards, the coordinate extremes
// and the heading wrap boundaries. A random set follows, weighted towards short
// offsets, axis offsets and headings near the half-turn points. Each accepted
// request is predicted in the bench and each result is compared field by field,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_pose_to_target_range_bearing;
  import pttrb_pkg::*;

  // Scaling constants of the fixed-point arithmetic
  localparam longint FULL_TURN   = 92160;      // heading, 1/256 degree
  localparam longint HALF_TURN   = 46080;
  localparam longint BEAR_180    = 11796480;   // bearing, 1/65536 degree
  localparam longint BEAR_90     = 5898240;
  localparam longint GAIN_Q30    = 652032874;  // inverse CORDIC gain, 2^30 scale
  localparam int     OFFSET_FRAC = 12;
  localparam int     ATAN_LEN    = 24;
  localparam int     PIPE_DEPTH  = CORDIC_STEPS + 4;
  localparam int     RANDOM_REQS = 1100;
  localparam int     REPORT_MAX  = 10;

  typedef struct packed {
    logic [XF_W-1:0]   cur_x;
    logic [XF_W-1:0]   cur_y;
    logic [HEAD_W-1:0] heading;
    logic [XF_W-1:0]   target_x;
    logic [XF_W-1:0]   target_y;
    logic              drain_first;  // hold until every result is back
  } pose_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TURN_W-1:0] turn_degrees;
  } nav_fix_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // atan(2^-i) in degrees, 1/65536 degree
  longint atan_step [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  pose_req_t pose_req_q [$];
  nav_fix_t  nav_fix_q [$];
  pose_req_t req_on_bus;
  int        reqs_total   = 0;
  int        reqs_sent    = 0;
  int        fixes_seen   = 0;
  int        fault_cnt    = 0;
  int        send_gap     = 0;
  int        recv_stall   = 0;

  pose_to_target_range_bearing dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Coordinate field as a COORD_BITS two's complement value
  function automatic longint coord_val(input logic [XF_W-1:0] f);
    longint unsigned u;
    u = 64'(f);
    return longint'(u << (64 - COORD_BITS)) >>> (64 - COORD_BITS);
  endfunction

  // Range and turn angle for one pose request
  function automatic nav_fix_t range_bearing(input pose_req_t r);
    longint          dx, dy, hd, wrapped, x, y, z, xs, ys, bear, turn;
    longint unsigned mag, ux, dist_val;
    nav_fix_t        fix;
    dx = coord_val(r.target_x) - coord_val(r.cur_x);
    dy = coord_val(r.target_y) - coord_val(r.cur_y);
    // wrap the heading into (-180, 180]
    hd = longint'(signed'(r.heading));
    mag = (hd < 0) ? -hd : hd;
    wrapped = longint'(mag % FULL_TURN);
    if (hd < 0) wrapped = -wrapped;
    if (wrapped > HALF_TURN) wrapped -= FULL_TURN;
    else if (wrapped <= -HALF_TURN) wrapped += FULL_TURN;
    if (dx == 0 && dy == 0) begin
      dist_val = 0;
      bear = 0;
    end else if (dy == 0) begin
      dist_val = (dx < 0) ? -dx : dx;
      bear = (dx > 0) ? 0 : BEAR_180;
    end else if (dx == 0) begin
      dist_val = (dy < 0) ? -dy : dy;
      bear = (dy > 0) ? BEAR_90 : -BEAR_90;
    end else begin
      x = dx <<< OFFSET_FRAC;
      y = dy <<< OFFSET_FRAC;
      z = 0;
      // turn a backward vector round by half a turn first
      if (dx < 0) begin
        x = -x;
        y = -y;
        z = (dy > 0) ? BEAR_180 : -BEAR_180;
      end
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      ux = (x < 0) ? 0 : x;
      dist_val = ((ux >> 16) * GAIN_Q30 + (((ux & 64'hFFFF) * GAIN_Q30) >> 16))
                 >> (30 + OFFSET_FRAC - 16);
      if (z > BEAR_180) z = BEAR_180;
      if (z < 1 - BEAR_180) z = 1 - BEAR_180;
      bear = z;
    end
    turn = (bear - wrapped * 256) / 65536;
    fix.distance     = dist_val[DIST_W-1:0];
    fix.turn_degrees = turn[TURN_W-1:0];
    return fix;
  endfunction

  function automatic pose_req_t pose_req(input int cx, input int cy, input int hd,
                                         input int tx, input int ty, input bit drain);
    pose_req_t r;
    r.cur_x       = cx[XF_W-1:0];
    r.cur_y       = cy[XF_W-1:0];
    r.heading     = hd;
    r.target_x    = tx[XF_W-1:0];
    r.target_y    = ty[XF_W-1:0];
    r.drain_first = drain;
    return r;
  endfunction

  function automatic int rand_heading();
    int k;
    k = int'($urandom_range(0, 46000)) - 23000;
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return k * 92160 + $urandom_range(0, 8) - 4;
      2:       return k * 92160 + 46080 + $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 184320) - 92160;
    endcase
  endfunction

  // Stimulus: directed set, then random mix; reset and end of run
  initial begin
    int cx, cy, tx, ty;
    // zero, on-axis and backward offsets
    pose_req_q.push_back(pose_req(100, -200, 0, 100, -200, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 0, 5000, 0, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 0, -5000, 0, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 0, 0, 7000, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 0, 0, -7000, 1'b0));
    pose_req_q.push_back(pose_req(10, 10, 2560, -300, 400, 1'b0));
    pose_req_q.push_back(pose_req(10, 10, -2560, -300, -400, 1'b0));
    pose_req_q.push_back(pose_req(3, -4, 0, 0, 0, 1'b0));
    // backward offsets close to the half-turn line
    pose_req_q.push_back(pose_req(32767, 0, 0, -32768, 1, 1'b0));
    pose_req_q.push_back(pose_req(32767, 0, 0, -32768, -1, 1'b0));
    // coordinate extremes
    pose_req_q.push_back(pose_req(-32768, -32768, 0, 32767, 32767, 1'b0));
    pose_req_q.push_back(pose_req(32767, 32767, 0, -32768, -32768, 1'b0));
    pose_req_q.push_back(pose_req(-32768, 32767, 0, 32767, -32768, 1'b0));
    pose_req_q.push_back(pose_req(32767, -32768, 0, -32768, 32767, 1'b0));
    // heading extremes and wrap boundaries
    pose_req_q.push_back(pose_req(0, 0, 32'h8000_0000, 1, 1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 32'h7FFF_FFFF, 1, 1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 46080, -1, 1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, -46080, -1, -1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 46081, 1, 0, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, -46081, 1, 0, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 92160, 0, 1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, -92160 * 3 - 46080, -2, -1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, 46079, -1, -1, 1'b0));
    pose_req_q.push_back(pose_req(0, 0, -46079, -1, 1, 1'b0));
    // random part
    for (int n = 0; n < RANDOM_REQS; n++) begin
      cx = $urandom_range(0, 65535);
      cy = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          tx = cx + $urandom_range(0, 16) - 8;
          ty = cy + $urandom_range(0, 16) - 8;
        end
        4, 5: begin
          tx = (n % 2) ? cx + $urandom_range(0, 65535) : cx;
          ty = (n % 2) ? cy : cy + $urandom_range(0, 65535);
        end
        6: begin
          tx = cx - $urandom_range(1, 65535);
          ty = cy + $urandom_range(0, 2) - 1;
        end
        default: begin
          tx = $urandom_range(0, 65535);
          ty = $urandom_range(0, 65535);
        end
      endcase
      pose_req_q.push_back(pose_req(cx, cy, rand_heading(), tx, ty,
                                    n == 0 || $urandom_range(0, 199) == 0));
    end
    reqs_total = pose_req_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_sent < reqs_total || nav_fix_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("timeout with %0d results outstanding", nav_fix_q.size());
    $display("status: fail");
    $finish;
  end

  // Request driver: predict on acceptance, idle between requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        nav_fix_q.push_back(range_bearing(req_on_bus));
        reqs_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pose_req_q.size() != 0 &&
                     !(pose_req_q[0].drain_first && nav_fix_q.size() != 0)) begin
          req_on_bus = pose_req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {req_on_bus.target_y, req_on_bus.target_x, req_on_bus.heading,
                        req_on_bus.cur_y, req_on_bus.cur_x};
          // every third stretch of a hundred requests runs back to back
          send_gap = ((reqs_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, stall at random
  always @(posedge clk) begin
    nav_fix_t fix_want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        fixes_seen++;
        if (nav_fix_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_MAX)
            $display("result %0d with no request outstanding: tdata %h",
                     fixes_seen, out_tdata);
        end else begin
          fix_want = nav_fix_q.pop_front();
          if (out_tdata[DIST_W-1:0] !== fix_want.distance ||
              out_tdata[DIST_W +: TURN_W] !== fix_want.turn_degrees ||
              out_tdata[OUT_TDATA_W-1:DIST_W+TURN_W] !== '0) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
              $display("result %0d: distance exp %0d got %0d, turn exp %0d got %0d, pad %b",
                       fixes_seen, fix_want.distance, out_tdata[DIST_W-1:0],
                       $signed(fix_want.turn_degrees), $signed(out_tdata[DIST_W +: TURN_W]),
                       out_tdata[OUT_TDATA_W-1:DIST_W+TURN_W]);
          end
        end
        recv_stall = ((fixes_seen / 100) % 3 == 2) ? 0 : $urandom_range(0, 3);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pttrb_pkg.sv
rtl/core/pttrb_prep.sv
rtl/core/pttrb_cordic.sv
rtl/core/pttrb_finish.sv
rtl/core/pose_to_target_range_bearing.sv
test/tb_pose_to_target_range_bearing.sv
